>>> rtl/core/vr2d_pkg.sv
// vr2d_pkg: types and fixed widths shared by the vector_reflect_2d pipeline.
// Depends on nothing; every rtl/core module refers to it by scoped names.
`default_nettype none

package vr2d_pkg;

   // input component width and the prescale bound on component magnitude
   localparam int          IN_WIDTH  = 16;
   localparam int unsigned PRE_LIMIT = 32768;

   // widths after prescale and through the reflection products
   localparam int PRE_W  = (IN_WIDTH > 16) ? 17 : IN_WIDTH;
   localparam int N2_W   = 2 * PRE_W;
   localparam int DOT_W  = 2 * PRE_W + 1;
   localparam int R_W    = 3 * PRE_W + 1;
   localparam int MAG_W  = 3 * PRE_W;
   localparam int POS_W  = $clog2(MAG_W);

   // normalized magnitude, sum of squares and square root
   localparam int NORM_W = 31;
   localparam int SQ_W   = 2 * NORM_W + 1;
   localparam int ROOT_W = 32;
   localparam int REM_W  = 2 * ROOT_W;

   // output code range
   localparam int          OUT_W       = 16;
   localparam int unsigned OUT_POS_MAX = 32767;
   localparam int unsigned OUT_NEG_MAX = 32768;

   typedef struct packed {
      logic signed [IN_WIDTH-1:0] in_x;
      logic signed [IN_WIDTH-1:0] in_y;
      logic signed [IN_WIDTH-1:0] nrm_x;
      logic signed [IN_WIDTH-1:0] nrm_y;
   } vr2d_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] out_x;
      logic signed [OUT_W-1:0] out_y;
      logic                    zero_length;
   } vr2d_rsp_type;

   typedef struct packed {
      logic [NORM_W-1:0] mag_x;
      logic [NORM_W-1:0] mag_y;
      logic              neg_x;
      logic              neg_y;
      logic              zero;
   } vr2d_side_type;

   typedef struct packed {
      logic              valid;
      vr2d_side_type     side;
      logic [SQ_W-1:0]   sq;
   } vr2d_sq_type;

   typedef struct packed {
      logic              valid;
      vr2d_side_type     side;
      logic [ROOT_W-1:0] root;
   } vr2d_root_type;

   typedef struct packed {
      logic         valid;
      vr2d_rsp_type rsp;
   } vr2d_out_type;

endpackage

`default_nettype wire

>>> rtl/core/vector_reflect_2d.sv
// vector_reflect_2d: reflects a 2D vector about a normal, unit result in signed fixed point.
// Path: req beat -> vr2d_front -> vr2d_sqrt -> vr2d_div -> rsp_valid, all registered.
// Throughput: one beat per cycle while req_ready is high; the 32 root stages and OUT_FRAC_BITS+1
// quotient stages set most of the depth. A one-entry output skid keeps req_ready registered.
// Reset: synchronous, clears stage valid bits and the skid; no clearing pass.
// Depends on vr2d_pkg, vr2d_front, vr2d_sqrt, vr2d_div.
`default_nettype none

module vector_reflect_2d #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_ready,
   input  vr2d_pkg::vr2d_req_type req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output vr2d_pkg::vr2d_rsp_type rsp_data
);

   logic                    ce;
   logic                    skid_full_ff, skid_full_in;
   vr2d_pkg::vr2d_rsp_type  skid_data_ff;
   vr2d_pkg::vr2d_sq_type   sq_bus;
   vr2d_pkg::vr2d_root_type root_bus;
   vr2d_pkg::vr2d_out_type  div_bus;

   assign ce        = !skid_full_ff;
   assign req_ready = ce;

   vr2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .req_valid (req_valid),
      .req_data  (req_data),
      .sq_out    (sq_bus)
   );

   vr2d_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .ce       (ce),
      .sq_in    (sq_bus),
      .root_out (root_bus)
   );

   vr2d_div #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .ce      (ce),
      .root_in (root_bus),
      .div_out (div_bus)
   );

   assign rsp_valid = skid_full_ff || div_bus.valid;
   assign rsp_data  = skid_full_ff ? skid_data_ff : div_bus.rsp;

   always_comb begin
      if (skid_full_ff) begin
         skid_full_in = !rsp_ready;
      end else begin
         skid_full_in = div_bus.valid && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_data_ff <= div_bus.rsp;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/vr2d_front.sv
// vr2d_front: prescale, reflection R = I*|N|^2 - 2(I.N)N, normalize, sum of squares.
// Nine register stages advanced by ce. Depends on vr2d_pkg.
`default_nettype none

module vr2d_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   ce,
   input  wire                   req_valid,
   input  vr2d_pkg::vr2d_req_type req_data,
   output vr2d_pkg::vr2d_sq_type  sq_out
);

   localparam int IW   = vr2d_pkg::IN_WIDTH;
   localparam int PW   = vr2d_pkg::PRE_W;
   localparam int N2W  = vr2d_pkg::N2_W;
   localparam int DW   = vr2d_pkg::DOT_W;
   localparam int RW   = vr2d_pkg::R_W;
   localparam int MW   = vr2d_pkg::MAG_W;
   localparam int PSW  = vr2d_pkg::POS_W;
   localparam int NW   = vr2d_pkg::NORM_W;
   localparam int QW   = vr2d_pkg::SQ_W;
   localparam int SH_W = $clog2(IW);

   function automatic logic [SH_W-1:0] pre_shift(input logic signed [IW-1:0] x,
                                                 input logic signed [IW-1:0] y);
      logic [IW-1:0]   mx;
      logic [IW-1:0]   my;
      logic [IW-1:0]   mm;
      logic [SH_W-1:0] kk;
      mx = x[IW-1] ? IW'(-x) : IW'(x);
      my = y[IW-1] ? IW'(-y) : IW'(y);
      mm = (mx > my) ? mx : my;
      kk = '0;
      for (int k = IW - 1; k >= 0; k--) begin
         if (33'(mm >> k) <= 33'(vr2d_pkg::PRE_LIMIT)) begin
            kk = SH_W'(k);
         end
      end
      return kk;
   endfunction

   function automatic logic signed [PW-1:0] pre_apply(input logic signed [IW-1:0] x,
                                                      input logic [SH_W-1:0] kk);
      logic [IW-1:0] mag;
      logic [IW:0]   sv;
      mag = x[IW-1] ? IW'(-x) : IW'(x);
      mag = mag >> kk;
      sv  = {1'b0, mag};
      if (x[IW-1]) begin
         sv = -sv;
      end
      return sv[PW-1:0];
   endfunction

   // valid chain
   logic [8:0] vld_ff;

   // stage 1
   logic signed [PW-1:0] s1_ax_ff, s1_ay_ff, s1_nx_ff, s1_ny_ff;
   logic                 s1_zero_ff;
   logic [SH_W-1:0]      sh_i, sh_n;
   // stage 2
   logic signed [N2W:0]  s2_n2_ff, s2_n2_in;
   logic signed [DW-1:0] s2_dot_ff, s2_dot_in;
   logic signed [PW-1:0] s2_ax_ff, s2_ay_ff, s2_nx_ff, s2_ny_ff;
   logic                 s2_zero_ff;
   // stage 3
   logic signed [RW-1:0] s3_pax_ff, s3_pay_ff, s3_pdx_ff, s3_pdy_ff;
   logic                 s3_zero_ff;
   // stage 4
   logic signed [RW-1:0] s4_rx_ff, s4_ry_ff;
   logic                 s4_zero_ff;
   // stage 5
   logic [MW-1:0]        s5_mx_ff, s5_my_ff, s5_mm_ff, s5_mx_in, s5_my_in, s5_mm_in;
   logic                 s5_negx_ff, s5_negy_ff, s5_zero_ff;
   // stage 6
   logic [MW-1:0]        s6_mx_ff, s6_my_ff;
   logic [PSW-1:0]       s6_pos_ff, s6_pos_in;
   logic                 s6_negx_ff, s6_negy_ff, s6_zero_ff;
   // stage 7
   vr2d_pkg::vr2d_side_type s7_side_ff, s7_side_in;
   logic [MW+NW-1:0]        ext_x, ext_y;
   logic [PSW:0]            sh_amt;
   // stage 8
   logic [2*NW-1:0]         s8_sqx_ff, s8_sqy_ff;
   vr2d_pkg::vr2d_side_type s8_side_ff;
   // stage 9
   logic [QW-1:0]           s9_sq_ff;
   vr2d_pkg::vr2d_side_type s9_side_ff;

   assign sh_i = pre_shift(req_data.in_x, req_data.in_y);
   assign sh_n = pre_shift(req_data.nrm_x, req_data.nrm_y);

   assign s2_n2_in  = (N2W+1)'(s1_nx_ff) * (N2W+1)'(s1_nx_ff)
                    + (N2W+1)'(s1_ny_ff) * (N2W+1)'(s1_ny_ff);
   assign s2_dot_in = DW'(s1_ax_ff) * DW'(s1_nx_ff) + DW'(s1_ay_ff) * DW'(s1_ny_ff);

   always_comb begin
      s5_mx_in = s4_rx_ff[RW-1] ? MW'(-s4_rx_ff) : MW'(s4_rx_ff);
      s5_my_in = s4_ry_ff[RW-1] ? MW'(-s4_ry_ff) : MW'(s4_ry_ff);
      s5_mm_in = (s5_mx_in > s5_my_in) ? s5_mx_in : s5_my_in;
   end

   always_comb begin
      s6_pos_in = '0;
      for (int i = 0; i < MW; i++) begin
         if (s5_mm_ff[i]) begin
            s6_pos_in = PSW'(i);
         end
      end
   end

   // leading one moves to bit NW-1
   always_comb begin
      sh_amt           = {1'b0, s6_pos_ff} + 1'b1;
      ext_x            = {s6_mx_ff, NW'(0)} >> sh_amt;
      ext_y            = {s6_my_ff, NW'(0)} >> sh_amt;
      s7_side_in.mag_x = ext_x[NW-1:0];
      s7_side_in.mag_y = ext_y[NW-1:0];
      s7_side_in.neg_x = s6_negx_ff;
      s7_side_in.neg_y = s6_negy_ff;
      s7_side_in.zero  = s6_zero_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[7:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_ax_ff   <= pre_apply(req_data.in_x, sh_i);
         s1_ay_ff   <= pre_apply(req_data.in_y, sh_i);
         s1_nx_ff   <= pre_apply(req_data.nrm_x, sh_n);
         s1_ny_ff   <= pre_apply(req_data.nrm_y, sh_n);
         s1_zero_ff <= (req_data.in_x == '0 && req_data.in_y == '0)
                    || (req_data.nrm_x == '0 && req_data.nrm_y == '0);

         s2_n2_ff   <= s2_n2_in;
         s2_dot_ff  <= s2_dot_in;
         s2_ax_ff   <= s1_ax_ff;
         s2_ay_ff   <= s1_ay_ff;
         s2_nx_ff   <= s1_nx_ff;
         s2_ny_ff   <= s1_ny_ff;
         s2_zero_ff <= s1_zero_ff;

         s3_pax_ff  <= RW'(s2_ax_ff) * RW'(s2_n2_ff);
         s3_pay_ff  <= RW'(s2_ay_ff) * RW'(s2_n2_ff);
         s3_pdx_ff  <= RW'(s2_dot_ff) * RW'(s2_nx_ff);
         s3_pdy_ff  <= RW'(s2_dot_ff) * RW'(s2_ny_ff);
         s3_zero_ff <= s2_zero_ff;

         s4_rx_ff   <= s3_pax_ff - (s3_pdx_ff <<< 1);
         s4_ry_ff   <= s3_pay_ff - (s3_pdy_ff <<< 1);
         s4_zero_ff <= s3_zero_ff;

         s5_mx_ff   <= s5_mx_in;
         s5_my_ff   <= s5_my_in;
         s5_mm_ff   <= s5_mm_in;
         s5_negx_ff <= s4_rx_ff[RW-1];
         s5_negy_ff <= s4_ry_ff[RW-1];
         s5_zero_ff <= s4_zero_ff || (s5_mm_in == '0);

         s6_mx_ff   <= s5_mx_ff;
         s6_my_ff   <= s5_my_ff;
         s6_pos_ff  <= s6_pos_in;
         s6_negx_ff <= s5_negx_ff;
         s6_negy_ff <= s5_negy_ff;
         s6_zero_ff <= s5_zero_ff;

         s7_side_ff <= s7_side_in;

         s8_sqx_ff  <= s7_side_ff.mag_x * s7_side_ff.mag_x;
         s8_sqy_ff  <= s7_side_ff.mag_y * s7_side_ff.mag_y;
         s8_side_ff <= s7_side_ff;

         s9_sq_ff   <= QW'(s8_sqx_ff) + QW'(s8_sqy_ff);
         s9_side_ff <= s8_side_ff;
      end
   end

   assign sq_out.valid = vld_ff[8];
   assign sq_out.side  = s9_side_ff;
   assign sq_out.sq    = s9_sq_ff;

endmodule

`default_nettype wire

>>> rtl/core/vr2d_sqrt.sv
// vr2d_sqrt: pipelined integer square root, one result bit per stage.
// ROOT_W stages advanced by ce. Depends on vr2d_pkg.
`default_nettype none

module vr2d_sqrt (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     ce,
   input  vr2d_pkg::vr2d_sq_type   sq_in,
   output vr2d_pkg::vr2d_root_type root_out
);

   localparam int RTW = vr2d_pkg::ROOT_W;
   localparam int RMW = vr2d_pkg::REM_W;

   logic [RTW-1:0] vld_ff;
   logic [RMW-1:0] rem_ff  [RTW];
   logic [RMW-1:0] res_ff  [RTW];
   vr2d_pkg::vr2d_side_type side_ff [RTW];

   logic [RMW-1:0] rem_src [RTW];
   logic [RMW-1:0] res_src [RTW];
   logic [RMW-1:0] rem_in  [RTW];
   logic [RMW-1:0] res_in  [RTW];
   logic [RMW-1:0] bit_k   [RTW];
   logic [RMW-1:0] trial   [RTW];
   vr2d_pkg::vr2d_side_type side_src [RTW];

   always_comb begin
      rem_src[0]  = RMW'(sq_in.sq);
      res_src[0]  = '0;
      side_src[0] = sq_in.side;
      for (int k = 1; k < RTW; k++) begin
         rem_src[k]  = rem_ff[k-1];
         res_src[k]  = res_ff[k-1];
         side_src[k] = side_ff[k-1];
      end
      for (int k = 0; k < RTW; k++) begin
         bit_k[k] = RMW'(1) << (2 * (RTW - 1 - k));
         trial[k] = res_src[k] | bit_k[k];
         if (rem_src[k] >= trial[k]) begin
            rem_in[k] = rem_src[k] - trial[k];
            res_in[k] = (res_src[k] >> 1) | bit_k[k];
         end else begin
            rem_in[k] = rem_src[k];
            res_in[k] = res_src[k] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ce) begin
         vld_ff <= {vld_ff[RTW-2:0], sq_in.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int k = 0; k < RTW; k++) begin
            rem_ff[k]  <= rem_in[k];
            res_ff[k]  <= res_in[k];
            side_ff[k] <= side_src[k];
         end
      end
   end

   assign root_out.valid = vld_ff[RTW-1];
   assign root_out.side  = side_ff[RTW-1];
   assign root_out.root  = res_ff[RTW-1][RTW-1:0];

endmodule

`default_nettype wire

>>> rtl/core/vr2d_div.sv
// vr2d_div: rounded scale-divide of both magnitudes by the root, then sign, saturate and zero-length override.
// OUT_FRAC_BITS+3 stages advanced by ce. Depends on vr2d_pkg.
`default_nettype none

module vr2d_div #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     ce,
   input  vr2d_pkg::vr2d_root_type root_in,
   output vr2d_pkg::vr2d_out_type  div_out
);

   localparam int RTW = vr2d_pkg::ROOT_W;
   localparam int QTW = OUT_FRAC_BITS + 1;
   localparam int DVW = RTW + OUT_FRAC_BITS;
   localparam int OW  = vr2d_pkg::OUT_W;

   // numerator stage
   logic                    s0_vld_ff;
   logic [DVW-1:0]          s0_numx_ff, s0_numy_ff;
   logic [RTW-1:0]          s0_den_ff;
   vr2d_pkg::vr2d_side_type s0_side_ff;

   // quotient stages, MSB first
   logic [QTW-1:0]          vld_ff;
   logic [DVW-1:0]          remx_ff [QTW];
   logic [DVW-1:0]          remy_ff [QTW];
   logic [QTW-1:0]          qx_ff   [QTW];
   logic [QTW-1:0]          qy_ff   [QTW];
   logic [RTW-1:0]          den_ff  [QTW];
   vr2d_pkg::vr2d_side_type side_ff [QTW];

   logic [DVW-1:0]          remx_src [QTW];
   logic [DVW-1:0]          remy_src [QTW];
   logic [QTW-1:0]          qx_src   [QTW];
   logic [QTW-1:0]          qy_src   [QTW];
   logic [RTW-1:0]          den_src  [QTW];
   vr2d_pkg::vr2d_side_type side_src [QTW];
   logic [DVW-1:0]          remx_in  [QTW];
   logic [DVW-1:0]          remy_in  [QTW];
   logic [QTW-1:0]          qx_in    [QTW];
   logic [QTW-1:0]          qy_in    [QTW];
   logic [DVW-1:0]          dsh      [QTW];
   logic [DVW:0]            difx     [QTW];
   logic [DVW:0]            dify     [QTW];

   // output stage
   logic                    out_vld_ff;
   vr2d_pkg::vr2d_rsp_type  out_ff, out_in;
   logic [QTW-1:0]          fin_qx, fin_qy;
   logic [16:0]             vx, vy;
   vr2d_pkg::vr2d_side_type fin_side;

   always_comb begin
      remx_src[0] = s0_numx_ff;
      remy_src[0] = s0_numy_ff;
      qx_src[0]   = '0;
      qy_src[0]   = '0;
      den_src[0]  = s0_den_ff;
      side_src[0] = s0_side_ff;
      for (int j = 1; j < QTW; j++) begin
         remx_src[j] = remx_ff[j-1];
         remy_src[j] = remy_ff[j-1];
         qx_src[j]   = qx_ff[j-1];
         qy_src[j]   = qy_ff[j-1];
         den_src[j]  = den_ff[j-1];
         side_src[j] = side_ff[j-1];
      end
      for (int j = 0; j < QTW; j++) begin
         dsh[j]     = DVW'(den_src[j]) << (QTW - 1 - j);
         difx[j]    = {1'b0, remx_src[j]} - {1'b0, dsh[j]};
         dify[j]    = {1'b0, remy_src[j]} - {1'b0, dsh[j]};
         remx_in[j] = difx[j][DVW] ? remx_src[j] : difx[j][DVW-1:0];
         remy_in[j] = dify[j][DVW] ? remy_src[j] : dify[j][DVW-1:0];
         qx_in[j]   = qx_src[j] | (QTW'(!difx[j][DVW]) << (QTW - 1 - j));
         qy_in[j]   = qy_src[j] | (QTW'(!dify[j][DVW]) << (QTW - 1 - j));
      end
   end

   // sign, saturate, zero-length override
   always_comb begin
      fin_qx   = qx_ff[QTW-1];
      fin_qy   = qy_ff[QTW-1];
      fin_side = side_ff[QTW-1];
      if (fin_side.neg_x) begin
         vx = (32'(fin_qx) > 32'(vr2d_pkg::OUT_NEG_MAX)) ? 17'(vr2d_pkg::OUT_NEG_MAX)
                                                        : 17'(fin_qx);
         vx = -vx;
      end else begin
         vx = (32'(fin_qx) > 32'(vr2d_pkg::OUT_POS_MAX)) ? 17'(vr2d_pkg::OUT_POS_MAX)
                                                        : 17'(fin_qx);
      end
      if (fin_side.neg_y) begin
         vy = (32'(fin_qy) > 32'(vr2d_pkg::OUT_NEG_MAX)) ? 17'(vr2d_pkg::OUT_NEG_MAX)
                                                        : 17'(fin_qy);
         vy = -vy;
      end else begin
         vy = (32'(fin_qy) > 32'(vr2d_pkg::OUT_POS_MAX)) ? 17'(vr2d_pkg::OUT_POS_MAX)
                                                        : 17'(fin_qy);
      end
      out_in.out_x       = fin_side.zero ? '0 : vx[OW-1:0];
      out_in.out_y       = fin_side.zero ? '0 : vy[OW-1:0];
      out_in.zero_length = fin_side.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff  <= 1'b0;
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (ce) begin
         s0_vld_ff  <= root_in.valid;
         vld_ff     <= {vld_ff[QTW-2:0], s0_vld_ff};
         out_vld_ff <= vld_ff[QTW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s0_numx_ff <= (DVW'(root_in.side.mag_x) << OUT_FRAC_BITS) + DVW'(root_in.root >> 1);
         s0_numy_ff <= (DVW'(root_in.side.mag_y) << OUT_FRAC_BITS) + DVW'(root_in.root >> 1);
         s0_den_ff  <= root_in.root;
         s0_side_ff <= root_in.side;
         for (int j = 0; j < QTW; j++) begin
            remx_ff[j] <= remx_in[j];
            remy_ff[j] <= remy_in[j];
            qx_ff[j]   <= qx_in[j];
            qy_ff[j]   <= qy_in[j];
            den_ff[j]  <= den_src[j];
            side_ff[j] <= side_src[j];
         end
         out_ff <= out_in;
      end
   end

   assign div_out.valid = out_vld_ff;
   assign div_out.rsp   = out_ff;

endmodule

`default_nettype wire
